@@ src/bpg_pkg.sv @@
package bpg_pkg;

   localparam int MAX_ELEMENTS_DEF = 8;
   localparam int COUNT_W = 4;
   localparam int SLOT_W = 3;
   localparam int VALUE_W = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_NEXT = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] element_value;
      logic [SLOT_W-1:0]         position;
      logic                      last;
      logic                      exhausted;
   } rsp_type;

   typedef struct packed {
      logic                      is_load;
      logic                      slot_ok;
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] value;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT,
      ST_EXHAUST
   } state_type;

endpackage

@@ src/bpg_front.sv @@
module bpg_front #(
   parameter int MAX_ELEMENTS = bpg_pkg::MAX_ELEMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpg_pkg::req_type  req_data,
   output logic              job_valid,
   output bpg_pkg::job_type  job,
   input  logic              job_pop
);

   localparam int PTR_W = $clog2(bpg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(bpg_pkg::QUEUE_DEPTH + 1);

   bpg_pkg::job_type  queue_ff [bpg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   bpg_pkg::job_type  new_job;
   logic              push;
   logic              pop;

   always_comb begin
      new_job.is_load = (req_data.cmd == bpg_pkg::CMD_LOAD);
      new_job.slot_ok = (32'(req_data.slot) < MAX_ELEMENTS);
      new_job.slot    = req_data.slot;
      new_job.value   = req_data.load_value;
   end

   assign req_stall = (fill_ff == CNT_W'(bpg_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign job_valid = (fill_ff != '0);
   assign pop       = job_pop && job_valid;
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = CNT_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = CNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

@@ src/bpg_back.sv @@
module bpg_back #(
   parameter int MAX_ELEMENTS = bpg_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  bpg_pkg::job_type             job,
   output logic                         job_pop,
   input  logic                         csr_write_enable,
   input  logic [bpg_pkg::COUNT_W-1:0]  csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bpg_pkg::rsp_type             rsp_data
);

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic signed [bpg_pkg::VALUE_W-1:0] stored_ff [MAX_ELEMENTS];
   logic                               store_we;

   logic [MAX_ELEMENTS-1:0][MAX_ELEMENTS-1:0] eq_ff, eq_in;
   logic [IDX_W-1:0]  stack_ff [MAX_ELEMENTS];
   logic [IDX_W-1:0]  stack_in [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]  d_ff, d_in;
   logic [CNT_W-1:0]  c_ff, c_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic              started_ff, started_in;
   logic              done_ff, done_in;
   logic [bpg_pkg::COUNT_W-1:0] count_ff, count_in;
   bpg_pkg::state_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bpg_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  n;
   logic [CNT_W-1:0]  nm1;
   logic [CNT_W-1:0]  dm1;
   logic [CNT_W-1:0]  dp1;
   logic [IDX_W-1:0]  c_idx;
   logic [IDX_W-1:0]  back_slot;
   logic [IDX_W-1:0]  resume_slot;
   logic              taken;
   logic              out_free;

   assign n = (count_ff > bpg_pkg::COUNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                           : CNT_W'(count_ff);
   assign nm1         = CNT_W'(n - 1'b1);
   assign dm1         = CNT_W'(d_ff - 1'b1);
   assign dp1         = CNT_W'(d_ff + 1'b1);
   assign c_idx       = c_ff[IDX_W-1:0];
   assign back_slot   = stack_ff[dm1[IDX_W-1:0]];
   assign resume_slot = stack_ff[nm1[IDX_W-1:0]];
   assign taken       = |(eq_ff[c_idx] & used_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign store_we    = (state_ff == bpg_pkg::ST_IDLE) && job_valid && job.is_load
                        && job.slot_ok;

   always_comb begin
      state_in     = state_ff;
      eq_in        = eq_ff;
      stack_in     = stack_ff;
      used_in      = used_ff;
      d_in         = d_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      started_in   = started_ff;
      done_in      = done_ff;
      count_in     = count_ff;
      job_pop      = 1'b0;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         bpg_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               if (job.is_load) begin
                  if (job.slot_ok) begin
                     for (int i = 0; i < MAX_ELEMENTS; i++) begin
                        for (int j = 0; j < MAX_ELEMENTS; j++) begin
                           if (i == j) begin
                              if (IDX_W'(i) == job.slot[IDX_W-1:0]) begin
                                 eq_in[i][j] = 1'b1;
                              end
                           end else if (IDX_W'(i) == job.slot[IDX_W-1:0]) begin
                              eq_in[i][j] = (job.value == stored_ff[j]);
                           end else if (IDX_W'(j) == job.slot[IDX_W-1:0]) begin
                              eq_in[i][j] = (job.value == stored_ff[i]);
                           end
                        end
                     end
                  end
                  started_in = 1'b0;
                  done_in    = 1'b0;
                  d_in       = '0;
               end else if (done_ff || n == '0) begin
                  state_in = bpg_pkg::ST_EXHAUST;
               end else if (!started_ff) begin
                  started_in = 1'b1;
                  d_in       = '0;
                  c_in       = '0;
                  used_in    = '0;
                  state_in   = bpg_pkg::ST_SEARCH;
               end else begin
                  d_in                 = nm1;
                  c_in                 = CNT_W'(CNT_W'(resume_slot) + 1'b1);
                  used_in[resume_slot] = 1'b0;
                  state_in             = bpg_pkg::ST_SEARCH;
               end
            end
         end
         bpg_pkg::ST_SEARCH: begin
            if (c_ff >= n) begin
               if (d_ff == '0) begin
                  state_in = bpg_pkg::ST_EXHAUST;
               end else begin
                  d_in               = dm1;
                  c_in               = CNT_W'(CNT_W'(back_slot) + 1'b1);
                  used_in[back_slot] = 1'b0;
               end
            end else if (taken) begin
               c_in = CNT_W'(c_ff + 1'b1);
            end else begin
               stack_in[d_ff[IDX_W-1:0]] = c_idx;
               used_in[c_idx]            = 1'b1;
               d_in                      = dp1;
               c_in                      = '0;
               if (dp1 == n) begin
                  k_in     = '0;
                  state_in = bpg_pkg::ST_EMIT;
               end
            end
         end
         bpg_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.element_value = stored_ff[stack_ff[k_ff]];
               rsp_data_in.position      = bpg_pkg::SLOT_W'(k_ff);
               rsp_data_in.last          = (CNT_W'(k_ff) == nm1);
               rsp_data_in.exhausted     = 1'b0;
               if (CNT_W'(k_ff) == nm1) begin
                  state_in = bpg_pkg::ST_IDLE;
               end else begin
                  k_in = IDX_W'(k_ff + 1'b1);
               end
            end
         end
         bpg_pkg::ST_EXHAUST: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.element_value = '0;
               rsp_data_in.position      = '0;
               rsp_data_in.last          = 1'b1;
               rsp_data_in.exhausted     = 1'b1;
               done_in                   = 1'b1;
               d_in                      = '0;
               state_in                  = bpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpg_pkg::ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         count_in   = csr_write_data;
         started_in = 1'b0;
         done_in    = 1'b0;
         d_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpg_pkg::ST_IDLE;
         eq_ff        <= '0;
         used_ff      <= '0;
         d_ff         <= '0;
         c_ff         <= '0;
         k_ff         <= '0;
         started_ff   <= 1'b0;
         done_ff      <= 1'b0;
         count_ff     <= bpg_pkg::COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ELEMENTS; i++) begin
            stack_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         eq_ff        <= eq_in;
         used_ff      <= used_in;
         d_ff         <= d_in;
         c_ff         <= c_in;
         k_ff         <= k_in;
         started_ff   <= started_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         stack_ff     <= stack_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (store_we) begin
         stored_ff[job.slot[IDX_W-1:0]] <= job.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/backtracking_permutation_generator.sv @@
// Backtracking permutation generator.
// Request channel (req_valid / req_stall / req_data): a load command stores
// load_value at slot and restarts the search; a next command yields the next
// permutation of the first element_count stored values in depth-first order.
// Response channel (rsp_valid / rsp_stall / rsp_data): a next command yields
// element_count transfers, position 0 upward, last set on the final one; once
// the search is exhausted it yields one transfer with exhausted and last set.
// csr_write_enable / csr_write_data set element_count and restart the search.
// Requests enter a two-entry queue, so a new request is taken while earlier
// work is still in the search engine. A load is applied as it is dequeued. A
// next command is dequeued, then runs the search one step at a time (one
// candidate test, one push or one backtrack), then sends its elements one
// at a time. Items are worked one at a time. When rsp_stall is high the
// output register holds its transfer and the engine waits to send the next;
// the queue keeps taking requests until it is full.
// Reset empties the queue, clears the search and sets element_count to 1;
// stored values are undefined until loaded.
module backtracking_permutation_generator #(
   parameter int MAX_ELEMENTS = bpg_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bpg_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bpg_pkg::rsp_type             rsp_data,
   input  logic                         csr_write_enable,
   input  logic [bpg_pkg::COUNT_W-1:0]  csr_write_data
);

   logic             job_valid;
   logic             job_pop;
   bpg_pkg::job_type job;

   bpg_front #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .job_valid(job_valid),
      .job      (job),
      .job_pop  (job_pop)
   );

   bpg_back #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job             (job),
      .job_pop         (job_pop),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

@@ sim/backtracking_permutation_generator_test.sv @@
`timescale 1ns / 1ps

module backtracking_permutation_generator_test;
   import bpg_pkg::*;

   localparam int SLOTS = MAX_ELEMENTS_DEF;
   localparam int RANDOM_ITEMS = 110;
   localparam int HOLD_CYCLES = 400;
   localparam int LOAD_SETTLE = 16;
   localparam int DRAIN_CYCLES = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam rsp_type EXHAUSTED_RSP = {{VALUE_W{1'b0}}, {SLOT_W{1'b0}}, 1'b1, 1'b1};

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_TYPED,
      ROW_COUNT
   } row_kind_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   typedef struct {
      row_kind_type       kind;
      req_type            req;
      logic [COUNT_W-1:0] count;
      rsp_type            answer;
   } dir_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_data;
   logic               csr_write_enable;
   logic [COUNT_W-1:0] csr_write_data;

   // permutation state mirrored from the block
   logic signed [VALUE_W-1:0] slot_values [SLOTS];
   logic [SLOT_W-1:0]         pick_stack [SLOTS];
   logic [COUNT_W-1:0]        count_reg;
   bit                        search_live;
   bit                        search_over;
   rsp_type                   produced [SLOTS];
   rsp_type                   pending_elements [$];
   dir_row_type               directed_rows [$];

   int burst_left = 0;
   int hold_asks = 0;
   int items_sent = 0;
   int random_items = 0;
   int count_writes = 0;
   int elements_checked = 0;
   int exhausted_seen = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   backtracking_permutation_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Resumes the depth-first search; fills produced[] and returns how many elements.
   function automatic int advance_permutation(req_type r);
      int n;
      int d;
      int c;
      int k;
      bit clash;
      n = (count_reg > SLOTS) ? SLOTS : int'(count_reg);
      if (r.cmd == CMD_LOAD) begin
         slot_values[r.slot] = r.load_value;
         search_live = 1'b0;
         search_over = 1'b0;
         return 0;
      end
      if (search_over || n == 0) begin
         search_over = 1'b1;
         produced[0] = EXHAUSTED_RSP;
         return 1;
      end
      if (!search_live) begin
         search_live = 1'b1;
         d = 0;
         c = 0;
      end else begin
         d = n - 1;
         c = int'(pick_stack[d]) + 1;
      end
      while (d < n) begin
         if (c >= n) begin
            if (d == 0) begin
               search_over = 1'b1;
               produced[0] = EXHAUSTED_RSP;
               return 1;
            end
            d--;
            c = int'(pick_stack[d]) + 1;
         end else begin
            clash = 1'b0;
            for (k = 0; k < d; k++)
               if (slot_values[pick_stack[k]] == slot_values[c]) clash = 1'b1;
            if (clash) begin
               c++;
            end else begin
               pick_stack[d] = c[SLOT_W-1:0];
               d++;
               c = 0;
            end
         end
      end
      for (k = 0; k < n; k++)
         produced[k] = {slot_values[pick_stack[k]], k[SLOT_W-1:0], k == n - 1, 1'b0};
      return n;
   endfunction

   function automatic dir_row_type dir_row(row_kind_type kind, logic cmd, int slot,
                                           logic [VALUE_W-1:0] value, int count,
                                           rsp_type answer);
      dir_row_type row;
      row.kind = kind;
      row.req = {cmd, slot[SLOT_W-1:0], value};
      row.count = count[COUNT_W-1:0];
      row.answer = answer;
      return row;
   endfunction

   task automatic send_request(req_type r, bit typed, rsp_type answer);
      int n;
      int k;
      if (burst_left == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
      n = advance_permutation(r);
      if (typed) begin
         pending_elements.push_back(answer);
      end else begin
         for (k = 0; k < n; k++) pending_elements.push_back(produced[k]);
      end
   endtask

   // element_count changes only once the block has gone quiet
   task automatic write_count(logic [COUNT_W-1:0] value);
      @(negedge clock) req_valid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock) csr_write_enable <= 1'b0;
      count_reg = value;
      search_live = 1'b0;
      search_over = 1'b0;
      count_writes++;
   endtask

   task automatic note_mismatch(string what, rsp_type want);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t %s: expected value %0d pos %0d last %0b exh %0b,",
                   " got value %0d pos %0d last %0b exh %0b"},
                  $time, what, want.element_value, want.position, want.last, want.exhausted,
                  rsp_data.element_value, rsp_data.position, rsp_data.last, rsp_data.exhausted);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         elements_checked++;
         if (rsp_data.exhausted) exhausted_seen++;
         if (pending_elements.size() == 0) begin
            note_mismatch("unexpected transfer", '0);
         end else begin
            want = pending_elements.pop_front();
            if (rsp_data.element_value !== want.element_value ||
                rsp_data.position !== want.position ||
                rsp_data.last !== want.last ||
                rsp_data.exhausted !== want.exhausted)
               note_mismatch("element mismatch", want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d elements still due",
                     quiet_cycles, pending_elements.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : receiver
      stall_mode_type mode;
      int mode_cycles;
      int served;
      rsp_stall = 1'b0;
      mode = STALL_NONE;
      mode_cycles = 0;
      served = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            served++;
            rsp_stall <= 1'b0;
         end else begin
            if (mode_cycles == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_cycles = $urandom_range(16, 96);
            end
            mode_cycles--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin : stimulus
      req_type r;
      logic [COUNT_W-1:0] cnt;
      int eff;
      int runs;
      int phase;
      int s;
      bit dup;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      count_reg = COUNT_W'(1);
      search_live = 1'b0;
      search_over = 1'b0;
      foreach (pick_stack[i]) pick_stack[i] = '0;

      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 0, 32'h7FFF_FFFF, 0, '0));
      directed_rows.push_back(dir_row(ROW_TYPED, CMD_NEXT, 0, 0, 0,
                                      {32'h7FFF_FFFF, 3'd0, 1'b1, 1'b0}));
      directed_rows.push_back(dir_row(ROW_TYPED, CMD_NEXT, 7, 32'hFFFF_FFFF, 0, EXHAUSTED_RSP));
      directed_rows.push_back(dir_row(ROW_TYPED, CMD_NEXT, 0, 0, 0, EXHAUSTED_RSP));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 0, 32'h8000_0000, 0, '0));
      directed_rows.push_back(dir_row(ROW_TYPED, CMD_NEXT, 0, 0, 0,
                                      {32'h8000_0000, 3'd0, 1'b1, 1'b0}));
      directed_rows.push_back(dir_row(ROW_COUNT, CMD_NEXT, 0, 0, 0, '0));
      directed_rows.push_back(dir_row(ROW_TYPED, CMD_NEXT, 0, 0, 0, EXHAUSTED_RSP));
      directed_rows.push_back(dir_row(ROW_COUNT, CMD_NEXT, 0, 0, 2, '0));
      // duplicate values: no permutation exists
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 1, 32'h8000_0000, 0, '0));
      directed_rows.push_back(dir_row(ROW_TYPED, CMD_NEXT, 0, 0, 0, EXHAUSTED_RSP));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 1, 32'hFFFF_FFFF, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_NEXT, 0, 0, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_NEXT, 0, 0, 0, '0));
      directed_rows.push_back(dir_row(ROW_TYPED, CMD_NEXT, 0, 0, 0, EXHAUSTED_RSP));
      // count above eight saturates
      directed_rows.push_back(dir_row(ROW_COUNT, CMD_NEXT, 0, 0, 15, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 2, 32'h0000_0000, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 3, 32'h0000_0001, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 4, 32'h5555_5555, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 5, 32'hAAAA_AAAA, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 6, 32'h0000_0002, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 7, 32'h0000_0003, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_NEXT, 0, 0, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_NEXT, 0, 0, 0, '0));
      directed_rows.push_back(dir_row(ROW_COUNT, CMD_NEXT, 0, 0, 3, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_NEXT, 0, 0, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_LOAD, 6, 32'h0000_0004, 0, '0));
      directed_rows.push_back(dir_row(ROW_PREDICT, CMD_NEXT, 0, 0, 0, '0));

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_COUNT: write_count(directed_rows[i].count);
            ROW_TYPED: send_request(directed_rows[i].req, 1'b1, directed_rows[i].answer);
            default:   send_request(directed_rows[i].req, 1'b0, '0);
         endcase
      end

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       cnt = COUNT_W'(0);
            1:       cnt = COUNT_W'(8);
            2:       cnt = COUNT_W'($urandom_range(9, 15));
            default: cnt = COUNT_W'($urandom_range(1, 5));
         endcase
         write_count(cnt);
         eff = (cnt > SLOTS) ? SLOTS : int'(cnt);
         dup = (eff > 1 && eff <= 4 && $urandom_range(0, 2) == 0);
         for (s = 0; s < eff; s++) begin
            r.cmd = CMD_LOAD;
            r.slot = s[SLOT_W-1:0];
            r.load_value = dup ? $urandom_range(0, eff - 1) : $urandom;
            send_request(r, 1'b0, '0);
            random_items++;
         end
         // long receiver hold-off so the request queue backs up
         if (phase % 6 == 1) hold_asks++;
         runs = (phase % 6 == 1) ? 12 : $urandom_range(1, 10);
         repeat (runs) begin
            if ($urandom_range(0, 7) == 0) begin
               r.cmd = CMD_LOAD;
               r.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
               r.load_value = $urandom;
               send_request(r, 1'b0, '0);
               random_items++;
            end
            r.cmd = CMD_NEXT;
            r.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            r.load_value = $urandom;
            send_request(r, 1'b0, '0);
            random_items++;
         end
         phase++;
      end

      @(negedge clock) req_valid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d random) across %0d element_count writes",
               items_sent, random_items, count_writes);
      $display("Checked %0d element transfers, %0d exhausted, %0d mismatches",
               elements_checked, exhausted_seen, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
